// ===== rtl/core/bmhq_pkg.sv =====
// bmhq_pkg: shared types and codes of the binary min-heap queue
// no dependencies; imported by binary_min_heap_queue
`default_nettype none

package bmhq_pkg;

	// operation carried in s_tuser
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// status carried in m_tuser
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_LOAD,
		S_DN_RD,
		S_DN_CMP,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/binary_min_heap_queue.sv =====
// binary_min_heap_queue: array-based binary min-heap of signed priorities
// depends on bmhq_pkg; heap entries live in an inferred memory inside this module
//
// Each word on the slave side is an insert (s_tuser = 0, priority in s_tdata) or a removal
// of the minimum (s_tuser = 1). Every word yields exactly one result word: status in m_tuser,
// and the new minimum, an empty flag and the entry count in m_tdata. An insert reads the
// parent in S_UP_RD and compares and writes in S_UP_CMP for each level the new value rises,
// going to S_DONE once it stops or reaches the root. A removal loads the last entry in
// S_DN_LOAD, then reads the children in S_DN_RD and compares and writes in S_DN_CMP for each
// level the moved entry sinks, going to S_DONE on a node without children; a removal that
// empties the heap goes from S_DN_LOAD to S_DONE, and a refused operation goes to S_DONE at
// once. The comparators and the single memory write port are shared by every level of the
// sift; each level costs a memory read step and a compare and write step. The block holds one
// word at a time: s_tready is low from acceptance until the result word has been taken.
`default_nettype none

module binary_min_heap_queue #(
	parameter int HEAP_DEPTH  = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] priority_req
	input  wire logic        s_tuser,   // [0] op
	// result side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [31:0] front_value, [32] is_empty, [39:33] entry_count
	output logic [1:0]       m_tuser    // [1:0] status
);
	import bmhq_pkg::*;

	localparam int IW   = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CNTW = $clog2(HEAP_DEPTH + 1);
	localparam int CW   = IW + 2;
	localparam int VW   = VALUE_WIDTH;
	localparam int XW   = (VW > 32) ? VW : 32;

	// heap storage, keys held with the sign bit flipped so unsigned compare orders them
	logic [VW-1:0] mem [HEAP_DEPTH];

	state_t         state_q, state_d;
	logic [CNTW-1:0] cnt_q;
	logic [IW-1:0]   idx_q, idx_d;
	logic [VW-1:0]   key_q, key_d;
	logic [VW-1:0]   rda_q, rdb_q;
	logic [VW-1:0]   front_q;
	status_t         status_q;
	logic            out_valid_q;
	logic [1:0]      out_status_q;
	logic [31:0]     out_front_q;
	logic            out_empty_q;
	logic [6:0]      out_count_q;

	logic            accept;
	logic            cnt_inc, cnt_dec;
	logic            we;
	logic [IW-1:0]   waddr, raddr_a, raddr_b;
	logic [VW-1:0]   wdata;
	logic [IW-1:0]   parent;
	logic [CW-1:0]   left_c, right_c, cnt_c;
	logic            left_in, right_in;
	logic            pick_right;
	logic [VW-1:0]   child_val;
	logic [IW-1:0]   child_idx;
	logic [XW-1:0]   pri_ext;
	logic [VW-1:0]   new_key;
	logic [VW-1:0]   front_raw;
	logic [XW-1:0]   front_ext;
	logic            full, empty;

	assign s_tready = (state_q == S_IDLE) && !out_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign full     = (cnt_q == CNTW'(HEAP_DEPTH));
	assign empty    = (cnt_q == '0);

	// incoming priority to biased key
	assign pri_ext = XW'(s_tdata);
	assign new_key = pri_ext[VW-1:0] ^ {1'b1, {(VW-1){1'b0}}};

	// tree addressing around the hole
	assign parent   = IW'((idx_q - IW'(1)) >> 1);
	assign left_c   = {1'b0, idx_q, 1'b1};
	assign right_c  = left_c + CW'(1);
	assign cnt_c    = CW'(cnt_q);
	assign left_in  = left_c < cnt_c;
	assign right_in = right_c < cnt_c;

	// shared comparator: smaller child, left wins ties
	assign pick_right = right_in && (rdb_q < rda_q);
	assign child_val  = pick_right ? rdb_q : rda_q;
	assign child_idx  = pick_right ? right_c[IW-1:0] : left_c[IW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (s_tuser == OP_INSERT) begin
						state_d = full ? S_DONE : S_UP_RD;
					end else begin
						state_d = empty ? S_DONE : S_DN_LOAD;
					end
				end
			end
			S_UP_RD:   state_d = (idx_q == '0) ? S_DONE : S_UP_CMP;
			S_UP_CMP:  state_d = (key_q < rda_q) ? S_UP_RD : S_DONE;
			S_DN_LOAD: state_d = empty ? S_DONE : S_DN_RD;
			S_DN_RD:   state_d = left_in ? S_DN_CMP : S_DONE;
			S_DN_CMP:  state_d = (child_val < key_q) ? S_DN_RD : S_DONE;
			S_DONE:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		we      = 1'b0;
		waddr   = idx_q;
		wdata   = key_q;
		raddr_a = left_c[IW-1:0];
		raddr_b = right_c[IW-1:0];
		idx_d   = idx_q;
		key_d   = key_q;
		cnt_inc = 1'b0;
		cnt_dec = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				raddr_a = IW'(cnt_q - CNTW'(1));
				if (accept) begin
					if (s_tuser == OP_INSERT) begin
						idx_d   = IW'(cnt_q);
						key_d   = new_key;
						cnt_inc = !full;
					end else begin
						cnt_dec = !empty;
					end
				end
			end
			S_UP_RD: begin
				raddr_a = parent;
				we      = (idx_q == '0);
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (key_q < rda_q) begin
					wdata = rda_q;
					idx_d = parent;
				end
			end
			S_DN_LOAD: begin
				key_d = rda_q;
				idx_d = '0;
			end
			S_DN_RD: begin
				we = !left_in;
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (child_val < key_q) begin
					wdata = child_val;
					idx_d = child_idx;
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// heap memory, one write and two registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rda_q <= mem[raddr_a];
		rdb_q <= mem[raddr_b];
	end

	// sequencer and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			status_q <= STAT_OK;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
			if (accept) begin
				if (s_tuser == OP_INSERT) begin
					status_q <= full ? STAT_FULL : STAT_OK;
				end else begin
					status_q <= empty ? STAT_EMPTY : STAT_OK;
				end
			end
		end
	end

	// payload registers, root copy follows every write to the root
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		key_q <= key_d;
		if (we && waddr == '0) begin
			front_q <= wdata;
		end
	end

	// root key back to a signed value
	assign front_raw = front_q ^ {1'b1, {(VW-1){1'b0}}};
	assign front_ext = XW'(signed'(front_raw));

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE) begin
			out_status_q <= status_q;
			out_front_q  <= empty ? 32'd0 : front_ext[31:0];
			out_empty_q  <= empty;
			out_count_q  <= 7'(cnt_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {out_count_q, out_empty_q, out_front_q};

	// fill count stays within the storage
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(HEAP_DEPTH))
		else $error("fill count beyond heap depth");

	// a result word follows only the end of a sequence
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result word raised outside the done step");

	// a refused insert leaves the count at full
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser == OP_INSERT && full |=> cnt_q == CNTW'(HEAP_DEPTH)
			&& status_q == STAT_FULL)
		else $error("refused insert changed the count");

	// a removal from a non-empty heap lowers the count by one
	a_rem_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser == OP_REMOVE && !empty |=> cnt_q == $past(cnt_q) - CNTW'(1))
		else $error("removal did not lower the count");

	// no new request while a sift is running
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !s_tready)
		else $error("ready during a sift");

endmodule

`default_nettype wire
